FILE: design/dif_pkg.sv
`default_nettype none

package dif_pkg;

    localparam int MAX_CHARS     = 64;
    localparam int VALUE_W       = 64;
    localparam int NUM_DIGITS    = 19;
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
    localparam int NDIG_W        = $clog2(NUM_DIGITS + 1);
    localparam int LEN_W         = 7;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);

    localparam logic [6:0] CH_ZERO  = 7'd48;
    localparam logic [6:0] CH_MINUS = 7'd45;
    localparam logic [6:0] CH_PLUS  = 7'd43;
    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [5:0] PREC_MAX = 6'd62;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      plus_sign;
        logic                      space_pad;
        logic                      zero_pad;
        logic                      left_justify;
        logic                      precision_given;
        logic [5:0]                precision;
        logic [5:0]                min_width;
    } dif_in_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       is_last;
        logic       no_char;
    } dif_out_t;

    typedef logic [NUM_DIGITS-1:0][3:0] dif_bcd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIZE,
        S_PAD,
        S_EMIT
    } dif_state_t;

endpackage

`default_nettype wire

FILE: design/dif_stream_if.sv
`default_nettype none

interface dif_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: design/decimal_integer_formatter.sv
// Signed decimal formatter, in the manner of a printf %d conversion.
// The number channel takes one request: a signed 64-bit value with its
// flags, precision and minimum width. The chars channel returns the text
// one ASCII character per request, the final one marked with is_last; an
// empty text returns a single request with no_char and is_last set.
// Both channels use a valid/ready handshake.
// The magnitude is converted to decimal by a shift-and-add-three loop that
// takes four bits a cycle in the S_CONV state. The S_SIZE state then sizes
// the body and the S_PAD state the padding, and in S_EMIT the first
// character is loaded into the output register; the text then follows at
// one character per cycle while the receiver is ready, up to 64
// characters. The block holds one request at a time and is ready again as
// soon as the last character sits in the output register, so it takes no
// new request before the whole text of the last one is loaded.
// A stalled receiver holds the output register and the character sequence
// waits with it. Reset empties the output register and returns the block
// to idle; no request is lost or repeated across a stall.
`default_nettype none

module decimal_integer_formatter (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dif_stream_if.sink   number,
    dif_stream_if.source chars
);

    import dif_pkg::*;

    dif_state_t               state_reg, state_next;
    logic [STEP_W-1:0]        step_reg;
    logic [VALUE_W-1:0]       mag_reg;
    dif_bcd_t                 bcd_reg;
    logic                     neg_reg, plus_reg, space_reg, zero_reg, left_reg, pok_reg;
    logic [5:0]               prec_reg, width_reg;
    logic [LEN_W-1:0]         len_reg, npad_reg, count_reg, pos_reg;
    logic                     ov_reg;
    dif_out_t                 out_reg;

    logic                     accept;
    logic                     load;
    logic                     last_char;
    logic                     conv_done;
    dif_bcd_t                 bcd_work;
    logic [VALUE_W-1:0]       mag_work;
    logic [VALUE_W-1:0]       mag_in;
    logic [NDIG_W-1:0]        ndig;
    logic [LEN_W-1:0]         base_len, len_calc, wide_len;
    logic [LEN_W-1:0]         w_ext, p_ext;
    logic                     zero_eff, pad_en;
    logic [LEN_W-1:0]         npad_calc, total_calc, count_calc;
    logic [LEN_W-1:0]         body_start, body_idx, dig_pos;
    logic                     in_body;
    logic [3:0]               digit;
    dif_out_t                 out_calc;

    assign accept    = number.valid && number.ready;
    assign conv_done = (step_reg == STEP_W'(CONV_STEPS - 1));
    assign load      = (state_reg == S_EMIT) && (!ov_reg || chars.ready);
    assign last_char = (count_reg == '0) || (pos_reg == count_reg - LEN_W'(1));

    assign number.ready  = (state_reg == S_IDLE);
    assign chars.valid   = ov_reg;
    assign chars.payload = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                state_next = S_PAD;
            end
            S_PAD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load && last_char)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mag_in = number.payload.value[VALUE_W-1]
                    ? (VALUE_W'(0) - VALUE_W'(number.payload.value))
                    : VALUE_W'(number.payload.value);

    always_comb
    begin
        bcd_work = bcd_reg;
        mag_work = mag_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_work[d] >= 4'd5)
                begin
                    bcd_work[d] = bcd_work[d] + 4'd3;
                end
            end
            bcd_work = (NUM_DIGITS * 4)'({bcd_work, mag_work[VALUE_W-1]});
            mag_work = {mag_work[VALUE_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        ndig = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                ndig = NDIG_W'(d + 1);
            end
        end
        w_ext    = LEN_W'(width_reg);
        p_ext    = LEN_W'(prec_reg);
        zero_eff = zero_reg && !pok_reg;
        base_len = LEN_W'(ndig)
                   + LEN_W'(neg_reg || (ndig == '0 && !pok_reg))
                   + LEN_W'(plus_reg && !neg_reg);
        wide_len = (w_ext > base_len) ? w_ext : base_len;
        if (zero_eff)
        begin
            len_calc = wide_len - LEN_W'(space_reg && width_reg != 6'd0);
        end
        else if (pok_reg && p_ext >= base_len)
        begin
            len_calc = p_ext + LEN_W'(neg_reg || plus_reg);
        end
        else
        begin
            len_calc = base_len;
        end
    end

    always_comb
    begin
        pad_en = (width_reg != 6'd0 && !(zero_reg && !pok_reg)) || space_reg;
        if (!pad_en)
        begin
            npad_calc = '0;
        end
        else if (w_ext > len_reg)
        begin
            npad_calc = w_ext - len_reg;
        end
        else
        begin
            npad_calc = LEN_W'(space_reg);
        end
        total_calc = len_reg + npad_calc;
        count_calc = (int'(total_calc) > MAX_CHARS) ? LEN_W'(MAX_CHARS) : total_calc;
    end

    always_comb
    begin
        body_start = left_reg ? '0 : npad_reg;
        in_body    = left_reg ? (pos_reg < len_reg) : (pos_reg >= npad_reg);
        body_idx   = pos_reg - body_start;
        dig_pos    = len_reg - LEN_W'(1) - body_idx;
        digit      = (int'(dig_pos) < NUM_DIGITS) ? bcd_reg[dig_pos[DIG_IDX_W-1:0]] : 4'd0;
        out_calc.is_last = last_char;
        out_calc.no_char = 1'b0;
        if (count_reg == '0)
        begin
            out_calc.char_code = 7'd0;
            out_calc.no_char   = 1'b1;
        end
        else if (!in_body)
        begin
            out_calc.char_code = CH_SPACE;
        end
        else if (body_idx == '0 && neg_reg)
        begin
            out_calc.char_code = CH_MINUS;
        end
        else if (body_idx == '0 && plus_reg)
        begin
            out_calc.char_code = CH_PLUS;
        end
        else
        begin
            out_calc.char_code = CH_ZERO + {3'b000, digit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_CONV)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (state_reg == S_PAD)
            begin
                pos_reg <= '0;
            end
            else if (load)
            begin
                pos_reg <= pos_reg + LEN_W'(1);
            end
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg   <= mag_in;
            bcd_reg   <= '0;
            neg_reg   <= number.payload.value[VALUE_W-1];
            plus_reg  <= number.payload.plus_sign;
            space_reg <= number.payload.space_pad && !number.payload.value[VALUE_W-1];
            zero_reg  <= number.payload.zero_pad;
            left_reg  <= number.payload.left_justify;
            pok_reg   <= number.payload.precision_given;
            prec_reg  <= (number.payload.precision > PREC_MAX) ? PREC_MAX
                                                               : number.payload.precision;
            width_reg <= number.payload.min_width;
        end
        else if (state_reg == S_CONV)
        begin
            mag_reg <= mag_work;
            bcd_reg <= bcd_work;
        end
        if (state_reg == S_SIZE)
        begin
            len_reg <= len_calc;
        end
        if (state_reg == S_PAD)
        begin
            npad_reg  <= npad_calc;
            count_reg <= count_calc;
        end
        if (load)
        begin
            out_reg <= out_calc;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.payload.no_char |-> chars.payload.is_last)
        else $error("empty text request without is_last");

    assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && !chars.payload.no_char |->
            (chars.payload.char_code >= CH_ZERO && chars.payload.char_code <= CH_ZERO + 7'd9)
            || chars.payload.char_code == CH_MINUS
            || chars.payload.char_code == CH_PLUS
            || chars.payload.char_code == CH_SPACE)
        else $error("character outside the decimal text set");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && count_reg != '0 |-> pos_reg < count_reg)
        else $error("character position ran past the text length");
`endif

endmodule

`default_nettype wire
